// ----- rtl/core/run_length_sample_logger_assert.svh -----
// Assertion macros for the run-length sample logger.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef RUN_LENGTH_SAMPLE_LOGGER_ASSERT_SVH
`define RUN_LENGTH_SAMPLE_LOGGER_ASSERT_SVH

// condition must hold at every edge out of reset
`define RLSL_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent must hold at the same edge as the antecedent
`define RLSL_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/rlsl_pkg.sv -----
// Package for the run-length sample logger: widths, codes, sequencer states
// and the ring slot reduction of a read index. No dependencies.
package rlsl_pkg;

    localparam int RING_DEPTH = 256;
    localparam int SLOT_W     = $clog2(RING_DEPTH);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);
    localparam logic [31:0] RING_DEPTH_W = 32'(RING_DEPTH);

    localparam int OP_W    = 2;
    localparam int TIME_W  = 32;
    localparam int VALUE_W = 24;
    localparam int FRAC_W  = 8;
    localparam int IV_W    = VALUE_W - FRAC_W;
    localparam int INDEX_W = 8;
    localparam int CNT_W   = 32;
    localparam int STAT_W  = 26;
    localparam int AVG_W   = VALUE_W;
    localparam int ACC_W   = AVG_W + CNT_W;

    localparam int DIV_STEPS  = AVG_W;
    localparam int DIV_STEP_W = $clog2(DIV_STEPS);
    localparam logic [DIV_STEP_W-1:0] DIV_LAST = DIV_STEP_W'(DIV_STEPS - 1);

    // 16364.0 and -16364.0 in signed Q18.8
    localparam logic signed [STAT_W-1:0] MIN_UNSET_Q = STAT_W'(16364 * 256);
    localparam logic signed [STAT_W-1:0] MAX_UNSET_Q = STAT_W'(-16364 * 256);

    localparam logic [OP_W-1:0] OP_LOG   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;

    typedef enum logic [1:0] {
        STAT_LOGGED  = 2'd0,
        STAT_STALE   = 2'd1,
        STAT_CLEARED = 2'd2,
        STAT_READ    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        SEQ_INIT,
        SEQ_IDLE,
        SEQ_RING_W,
        SEQ_RING_CMP,
        SEQ_RING_W2,
        SEQ_MUL,
        SEQ_DIV_LD,
        SEQ_DIV,
        SEQ_CLEAR,
        SEQ_ENTRY_RD,
        SEQ_ENTRY_CAP,
        SEQ_SPAN_A,
        SEQ_SPAN_B,
        SEQ_DONE
    } seq_state_t;

    // index mod RING_DEPTH by restoring remainder, one bit of the index a step
    function automatic logic [SLOT_W-1:0] idx_slot(input logic [INDEX_W-1:0] idx);
        logic [31:0] r;
        r = {{(32-INDEX_W){1'b0}}, idx};
        for (int k = INDEX_W - 1; k >= 0; k--)
        begin
            if (r >= (RING_DEPTH_W << k))
            begin
                r = r - (RING_DEPTH_W << k);
            end
        end
        return r[SLOT_W-1:0];
    endfunction

endpackage

// ----- rtl/core/rlsl_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// Stand-alone, no package dependency.
module rlsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/run_length_sample_logger.sv -----
// Run-length sample logger: top level, sequencer, statistics and ring control.
// Depends on rlsl_pkg, rlsl_ram and run_length_sample_logger_assert.svh.
//
// Request channel (req_valid/req_stall) carries op, time_req, value, index;
// response channel (rsp_valid/rsp_stall) returns one result per request.
// A request is taken only when the sequencer is idle; one transaction is
// worked at a time. States from acceptance to result valid:
//   logged sample   ring update, multiply, load, 24 one-bit steps of the
//                   restoring divider, span reads; stale sample: span reads
//   clear: slot-zero write, span reads; entry read: read, capture, span reads
// The next request is taken in the cycle after the result is registered, so a
// new sample waits for the last; a logged one's occupancy is set by the divider.
// The result sits in an output register: a stalled receiver holds it while
// the next request is already worked, and that request waits to complete
// until the register is free.
// After reset the sequencer sweeps both ring RAMs to zero, one slot per
// cycle, all RING_DEPTH (256) slots, with req_stall high throughout.
`include "run_length_sample_logger_assert.svh"

module run_length_sample_logger (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic [rlsl_pkg::OP_W-1:0]           op,
    input  logic [rlsl_pkg::TIME_W-1:0]         time_req,
    input  logic [rlsl_pkg::VALUE_W-1:0]        value,
    input  logic [rlsl_pkg::INDEX_W-1:0]        index,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output rlsl_pkg::status_t                   status,
    output logic [rlsl_pkg::CNT_W-1:0]          samples_seen,
    output logic [rlsl_pkg::CNT_W-1:0]          write_position,
    output logic signed [rlsl_pkg::STAT_W-1:0]  minimum,
    output logic signed [rlsl_pkg::STAT_W-1:0]  maximum,
    output logic signed [rlsl_pkg::STAT_W-1:0]  average,
    output logic [rlsl_pkg::CNT_W-1:0]          span_count,
    output logic [rlsl_pkg::CNT_W-1:0]          entry_sample,
    output logic [rlsl_pkg::IV_W-1:0]           entry_value
);

    import rlsl_pkg::*;

    // sequencer and architectural state
    seq_state_t               state_reg, state_next;
    logic [TIME_W-1:0]        last_time_reg, last_time_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]         wp_reg, wp_next;
    logic [SLOT_W-1:0]        wp_slot_reg, wp_slot_next;
    logic signed [STAT_W-1:0] min_reg, min_next;
    logic signed [STAT_W-1:0] max_reg, max_next;
    logic [AVG_W-1:0]         avg_reg, avg_next;
    logic [SLOT_W-1:0]        sweep_reg, sweep_next;
    logic [DIV_STEP_W-1:0]    div_step_reg, div_step_next;
    logic                     rsp_valid_reg, rsp_valid_next;

    // working registers
    logic [VALUE_W-1:0]       val_reg, val_next;
    status_t                  stat_reg, stat_next;
    logic [SLOT_W-1:0]        rd_slot_reg, rd_slot_next;
    logic [ACC_W-1:0]         prod_reg, prod_next;
    logic [CNT_W-1:0]         rem_reg, rem_next;
    logic [AVG_W-1:0]         dq_reg, dq_next;
    logic [CNT_W-1:0]         n_last_reg, n_last_next;
    logic [CNT_W-1:0]         entry_n_reg, entry_n_next;
    logic [IV_W-1:0]          entry_v_reg, entry_v_next;

    // result register
    status_t                  rsp_status_reg, rsp_status_next;
    logic [CNT_W-1:0]         rsp_cnt_reg, rsp_cnt_next;
    logic [CNT_W-1:0]         rsp_wp_reg, rsp_wp_next;
    logic signed [STAT_W-1:0] rsp_min_reg, rsp_min_next;
    logic signed [STAT_W-1:0] rsp_max_reg, rsp_max_next;
    logic [AVG_W-1:0]         rsp_avg_reg, rsp_avg_next;
    logic [CNT_W-1:0]         rsp_span_reg, rsp_span_next;
    logic [CNT_W-1:0]         rsp_entry_n_reg, rsp_entry_n_next;
    logic [IV_W-1:0]          rsp_entry_v_reg, rsp_entry_v_next;

    // ring RAM ports
    logic                     n_we, v_we, rd_en;
    logic [SLOT_W-1:0]        wr_addr, rd_addr;
    logic [CNT_W-1:0]         n_wdata, n_rdata;
    logic [IV_W-1:0]          v_wdata, v_rdata;

    // combinational helpers
    logic [IV_W-1:0]          iv;
    logic signed [STAT_W-1:0] sample_q;
    logic [SLOT_W-1:0]        slot_wrap, slot_inc, prev_slot, first_slot;
    logic [CNT_W-1:0]         cnt_m1;
    logic [ACC_W-1:0]         acc_sum;
    logic [CNT_W:0]           div_trial;
    logic                     div_ge;
    logic [CNT_W-1:0]         div_rem_step;
    logic [AVG_W-1:0]         div_q_step;
    logic [CNT_W-1:0]         span_calc;
    seq_state_t               after_ring;

    rlsl_ram #(
        .WIDTH (CNT_W),
        .DEPTH (RING_DEPTH)
    ) u_num_ram (
        .clk   (clk),
        .we    (n_we),
        .waddr (wr_addr),
        .wdata (n_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (n_rdata)
    );

    rlsl_ram #(
        .WIDTH (IV_W),
        .DEPTH (RING_DEPTH)
    ) u_val_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (wr_addr),
        .wdata (v_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (v_rdata)
    );

    assign iv       = val_reg[VALUE_W-1:FRAC_W];
    assign sample_q = $signed({{(STAT_W-VALUE_W){1'b0}}, value});

    // slot arithmetic follows the 32-bit position without a divider
    assign slot_wrap  = (wp_slot_reg == SLOT_LAST) ? {SLOT_W{1'b0}}
                                                   : wp_slot_reg + SLOT_W'(1);
    assign slot_inc   = (wp_reg == {CNT_W{1'b1}}) ? {SLOT_W{1'b0}} : slot_wrap;
    assign prev_slot  = (wp_slot_reg != {SLOT_W{1'b0}}) ? wp_slot_reg - SLOT_W'(1)
                      : ((wp_reg >= RING_DEPTH_W) ? SLOT_LAST : {SLOT_W{1'b0}});
    assign first_slot = (wp_reg > RING_DEPTH_W) ? slot_wrap : {SLOT_W{1'b0}};

    assign cnt_m1  = cnt_reg - CNT_W'(1);
    assign acc_sum = prod_reg + {{CNT_W{1'b0}}, val_reg};

    // one quotient bit per step; remainder stays below the count
    assign div_trial    = {rem_reg, dq_reg[AVG_W-1]};
    assign div_ge       = (div_trial >= {1'b0, cnt_reg});
    assign div_rem_step = div_ge ? CNT_W'(div_trial - {1'b0, cnt_reg})
                                 : div_trial[CNT_W-1:0];
    assign div_q_step   = {dq_reg[AVG_W-2:0], div_ge};

    assign span_calc  = (wp_reg != {CNT_W{1'b0}}) ? n_last_reg - n_rdata + CNT_W'(1)
                                                  : n_last_reg;
    assign after_ring = (cnt_reg == {CNT_W{1'b0}}) ? SEQ_SPAN_A : SEQ_MUL;

    assign req_stall = (state_reg != SEQ_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        last_time_next   = last_time_reg;
        cnt_next         = cnt_reg;
        wp_next          = wp_reg;
        wp_slot_next     = wp_slot_reg;
        min_next         = min_reg;
        max_next         = max_reg;
        avg_next         = avg_reg;
        sweep_next       = sweep_reg;
        div_step_next    = div_step_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        val_next         = val_reg;
        stat_next        = stat_reg;
        rd_slot_next     = rd_slot_reg;
        prod_next        = prod_reg;
        rem_next         = rem_reg;
        dq_next          = dq_reg;
        n_last_next      = n_last_reg;
        entry_n_next     = entry_n_reg;
        entry_v_next     = entry_v_reg;
        rsp_status_next  = rsp_status_reg;
        rsp_cnt_next     = rsp_cnt_reg;
        rsp_wp_next      = rsp_wp_reg;
        rsp_min_next     = rsp_min_reg;
        rsp_max_next     = rsp_max_reg;
        rsp_avg_next     = rsp_avg_reg;
        rsp_span_next    = rsp_span_reg;
        rsp_entry_n_next = rsp_entry_n_reg;
        rsp_entry_v_next = rsp_entry_v_reg;
        n_we             = 1'b0;
        v_we             = 1'b0;
        wr_addr          = {SLOT_W{1'b0}};
        n_wdata          = {CNT_W{1'b0}};
        v_wdata          = {IV_W{1'b0}};
        rd_en            = 1'b0;
        rd_addr          = {SLOT_W{1'b0}};

        case (state_reg)
            SEQ_INIT:
            begin
                n_we    = 1'b1;
                v_we    = 1'b1;
                wr_addr = sweep_reg;
                if (sweep_reg == SLOT_LAST)
                begin
                    state_next = SEQ_IDLE;
                end
                sweep_next = sweep_reg + SLOT_W'(1);
            end

            SEQ_IDLE:
            begin
                if (req_valid)
                begin
                    val_next     = value;
                    entry_n_next = {CNT_W{1'b0}};
                    entry_v_next = {IV_W{1'b0}};
                    case (op)
                        OP_LOG:
                        begin
                            if (time_req > last_time_reg)
                            begin
                                last_time_next = time_req;
                                cnt_next       = cnt_reg + CNT_W'(1);
                                if (max_reg < sample_q)
                                begin
                                    max_next = sample_q;
                                end
                                if (min_reg > sample_q)
                                begin
                                    min_next = sample_q;
                                end
                                stat_next  = STAT_LOGGED;
                                state_next = SEQ_RING_W;
                            end
                            else
                            begin
                                stat_next  = STAT_STALE;
                                state_next = SEQ_SPAN_A;
                            end
                        end
                        OP_CLEAR:
                        begin
                            last_time_next = {TIME_W{1'b0}};
                            cnt_next       = {CNT_W{1'b0}};
                            wp_next        = {CNT_W{1'b0}};
                            wp_slot_next   = {SLOT_W{1'b0}};
                            min_next       = MIN_UNSET_Q;
                            max_next       = MAX_UNSET_Q;
                            avg_next       = {AVG_W{1'b0}};
                            stat_next      = STAT_CLEARED;
                            state_next     = SEQ_CLEAR;
                        end
                        default:
                        begin
                            // both codes with the upper bit set read an entry
                            rd_slot_next = idx_slot(index);
                            stat_next    = STAT_READ;
                            state_next   = SEQ_ENTRY_RD;
                        end
                    endcase
                end
            end

            SEQ_RING_W:
            begin
                n_we    = 1'b1;
                v_we    = 1'b1;
                wr_addr = wp_slot_reg;
                n_wdata = cnt_reg;
                v_wdata = iv;
                if (cnt_reg == CNT_W'(1))
                begin
                    // first sample after clear: opens a run and the next one
                    wp_next      = wp_reg + CNT_W'(1);
                    wp_slot_next = slot_inc;
                    state_next   = SEQ_RING_W2;
                end
                else if (wp_reg == {CNT_W{1'b0}})
                begin
                    // previous slot is the one just written
                    state_next = after_ring;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = prev_slot;
                    state_next = SEQ_RING_CMP;
                end
            end

            SEQ_RING_CMP:
            begin
                if (v_rdata != iv)
                begin
                    wp_next      = wp_reg + CNT_W'(1);
                    wp_slot_next = slot_inc;
                    state_next   = SEQ_RING_W2;
                end
                else
                begin
                    state_next = after_ring;
                end
            end

            SEQ_RING_W2:
            begin
                n_we       = 1'b1;
                v_we       = 1'b1;
                wr_addr    = wp_slot_reg;
                n_wdata    = cnt_reg;
                v_wdata    = iv;
                state_next = after_ring;
            end

            SEQ_MUL:
            begin
                prod_next  = {{CNT_W{1'b0}}, avg_reg} * {{AVG_W{1'b0}}, cnt_m1};
                state_next = SEQ_DIV_LD;
            end

            SEQ_DIV_LD:
            begin
                rem_next      = acc_sum[ACC_W-1:AVG_W];
                dq_next       = acc_sum[AVG_W-1:0];
                div_step_next = {DIV_STEP_W{1'b0}};
                state_next    = SEQ_DIV;
            end

            SEQ_DIV:
            begin
                rem_next      = div_rem_step;
                dq_next       = div_q_step;
                div_step_next = div_step_reg + DIV_STEP_W'(1);
                if (div_step_reg == DIV_LAST)
                begin
                    avg_next   = div_q_step;
                    state_next = SEQ_SPAN_A;
                end
            end

            SEQ_CLEAR:
            begin
                // only the sample number of slot zero is cleared
                n_we       = 1'b1;
                wr_addr    = {SLOT_W{1'b0}};
                n_wdata    = {CNT_W{1'b0}};
                state_next = SEQ_SPAN_A;
            end

            SEQ_ENTRY_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = rd_slot_reg;
                state_next = SEQ_ENTRY_CAP;
            end

            SEQ_ENTRY_CAP:
            begin
                entry_n_next = n_rdata;
                entry_v_next = v_rdata;
                state_next   = SEQ_SPAN_A;
            end

            SEQ_SPAN_A:
            begin
                rd_en      = 1'b1;
                rd_addr    = wp_slot_reg;
                state_next = SEQ_SPAN_B;
            end

            SEQ_SPAN_B:
            begin
                n_last_next = n_rdata;
                rd_en       = 1'b1;
                rd_addr     = first_slot;
                state_next  = SEQ_DONE;
            end

            SEQ_DONE:
            begin
                // read data of the first slot is held until the next read
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_status_next  = stat_reg;
                    rsp_cnt_next     = cnt_reg;
                    rsp_wp_next      = wp_reg;
                    rsp_min_next     = min_reg;
                    rsp_max_next     = max_reg;
                    rsp_avg_next     = avg_reg;
                    rsp_span_next    = span_calc;
                    rsp_entry_n_next = entry_n_reg;
                    rsp_entry_v_next = entry_v_reg;
                    state_next       = SEQ_IDLE;
                end
            end

            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= {TIME_W{1'b0}};
            cnt_reg       <= {CNT_W{1'b0}};
            wp_reg        <= {CNT_W{1'b0}};
            wp_slot_reg   <= {SLOT_W{1'b0}};
            min_reg       <= MIN_UNSET_Q;
            max_reg       <= MAX_UNSET_Q;
            avg_reg       <= {AVG_W{1'b0}};
            sweep_reg     <= {SLOT_W{1'b0}};
            div_step_reg  <= {DIV_STEP_W{1'b0}};
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            last_time_reg <= last_time_next;
            cnt_reg       <= cnt_next;
            wp_reg        <= wp_next;
            wp_slot_reg   <= wp_slot_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            avg_reg       <= avg_next;
            sweep_reg     <= sweep_next;
            div_step_reg  <= div_step_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg         <= val_next;
        stat_reg        <= stat_next;
        rd_slot_reg     <= rd_slot_next;
        prod_reg        <= prod_next;
        rem_reg         <= rem_next;
        dq_reg          <= dq_next;
        n_last_reg      <= n_last_next;
        entry_n_reg     <= entry_n_next;
        entry_v_reg     <= entry_v_next;
        rsp_status_reg  <= rsp_status_next;
        rsp_cnt_reg     <= rsp_cnt_next;
        rsp_wp_reg      <= rsp_wp_next;
        rsp_min_reg     <= rsp_min_next;
        rsp_max_reg     <= rsp_max_next;
        rsp_avg_reg     <= rsp_avg_next;
        rsp_span_reg    <= rsp_span_next;
        rsp_entry_n_reg <= rsp_entry_n_next;
        rsp_entry_v_reg <= rsp_entry_v_next;
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = rsp_status_reg;
    assign samples_seen   = rsp_cnt_reg;
    assign write_position = rsp_wp_reg;
    assign minimum        = rsp_min_reg;
    assign maximum        = rsp_max_reg;
    assign average        = $signed({{(STAT_W-AVG_W){1'b0}}, rsp_avg_reg});
    assign span_count     = rsp_span_reg;
    assign entry_sample   = rsp_entry_n_reg;
    assign entry_value    = rsp_entry_v_reg;

    `RLSL_ASSERT_IMPLIES(a_div_rem_below_count, state_reg == SEQ_DIV, rem_reg < cnt_reg, "divider remainder not below sample count")
    `RLSL_ASSERT_IMPLIES(a_ram_no_overlap, (n_we || v_we) && rd_en, wr_addr != rd_addr, "ring read and write hit the same slot")
    `RLSL_ASSERT_IMPLIES(a_rsp_from_done, $rose(rsp_valid_reg), $past(state_reg == SEQ_DONE), "result raised outside completion")
    `RLSL_ASSERT_IMPLIES(a_min_le_max, cnt_reg != {CNT_W{1'b0}}, min_reg <= max_reg, "minimum above maximum with samples seen")

endmodule
